/* hw/rtl/mwps_pkg.sv */
package mwps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int COUNT_WIDTH = 16;

    localparam int CFG_LEN_W = 5;
    localparam int IDX_W     = 4;
    localparam int LEN_CW    = $clog2(MAX_PATTERN + 1);
    localparam int LMAX_W    = (LEN_CW > CFG_LEN_W) ? LEN_CW : CFG_LEN_W;
    localparam int SHOW_W    = 16;
    localparam int WIDE_W    = (COUNT_WIDTH > SHOW_W) ? COUNT_WIDTH : SHOW_W;
    localparam int SEL_W     = LEN_CW + IDX_W;

    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_SCAN = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_UNIQUE = 2'd1,
        ST_AMBIG  = 2'd2
    } t_status;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_PATTERN_LENGTH = 1'b0
    } t_reg;

    typedef logic [LEN_CW-1:0] t_len;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   entry_index;
        logic [31:0]        pattern_word;
        logic [31:0]        pattern_mask;
        logic [31:0]        word_address;
        logic [31:0]        code_word;
        logic               section_start;
        logic               scan_end;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [31:0]        match_address;
        logic [SHOW_W-1:0]  hit_count;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic scan;
        logic scan_end;
        logic active;
        logic is_last;
    } t_cell_ctl;

    typedef struct packed {
        logic        scan;
        logic        scan_end;
        logic        match;
        t_len        len;
        logic [31:0] address;
    } t_scan_ev;

endpackage

/* hw/rtl/mwps_if.sv */
interface mwps_in_if;
    import mwps_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mwps_out_if;
    import mwps_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/masked_word_pattern_scanner_core.sv */
// Masked word pattern scanner. Scan words enter at one per cycle while input
// ready is high: a row of MAX_PATTERN compare cells checks each word against
// every pattern position in the cycle it is accepted, each cell passing its
// partial-match bit to its neighbor. A scan_end word's result is registered
// into the output register, or into the skid entry while the output register
// holds an undelivered result; input ready drops only while both hold
// undelivered results. pattern_length sits at APB offset 0x0. The user must
// write it only while no scan is in flight; the block does not enforce this.
// Values above MAX_PATTERN act as MAX_PATTERN, and zero disables matching.
module masked_word_pattern_scanner_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mwps_in_if.sink                     i_in,
    mwps_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mwps_pkg::APB_AW-1:0] paddr,
    input  logic [mwps_pkg::APB_DW-1:0] pwdata,
    output logic [mwps_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import mwps_pkg::*;

    logic [CFG_LEN_W-1:0]   r_len;
    logic [LMAX_W-1:0]      w_len_ext;
    t_len                   w_len;
    t_reg                   w_reg;
    logic                   w_acc;
    logic                   w_scan;
    logic                   w_load;
    logic                   w_in_ready;
    logic [MAX_PATTERN-1:0] w_bit;
    logic [MAX_PATTERN-1:0] w_prev;
    logic [MAX_PATTERN-1:0] w_match;
    t_scan_ev               w_ev;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (psel && penable && pwrite && (w_reg == REG_PATTERN_LENGTH)) begin
            r_len <= pwdata[CFG_LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg == REG_PATTERN_LENGTH) begin
            prdata = APB_DW'(r_len);
        end
    end

    always_comb begin
        w_len_ext = LMAX_W'(r_len);
        if (w_len_ext > LMAX_W'(MAX_PATTERN)) begin
            w_len = LEN_CW'(MAX_PATTERN);
        end else begin
            w_len = LEN_CW'(w_len_ext);
        end
    end

    assign i_in.ready = w_in_ready;
    assign w_acc      = i_in.valid && w_in_ready;
    assign w_scan     = w_acc && (i_in.data.op == OP_SCAN);
    assign w_load     = w_acc && (i_in.data.op == OP_LOAD);

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        t_cell_ctl w_ctl;

        if (j == 0) begin : g_head
            assign w_prev[j] = 1'b1;
        end else begin : g_body
            // new section: the neighbor's partial match is dropped
            assign w_prev[j] = w_bit[j-1] && !i_in.data.section_start;
        end

        assign w_ctl.load     = w_load &&
                                (SEL_W'(i_in.data.entry_index) == SEL_W'(j));
        assign w_ctl.scan     = w_scan;
        assign w_ctl.scan_end = i_in.data.scan_end;
        assign w_ctl.active   = LEN_CW'(j) < w_len;
        assign w_ctl.is_last  = w_len == LEN_CW'(j + 1);

        mwps_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_prev         (w_prev[j]),
            .i_pattern_word (i_in.data.pattern_word),
            .i_pattern_mask (i_in.data.pattern_mask),
            .i_code_word    (i_in.data.code_word),
            .o_bit          (w_bit[j]),
            .o_match        (w_match[j])
        );
    end

    assign w_ev.scan     = w_scan;
    assign w_ev.scan_end = i_in.data.scan_end;
    assign w_ev.match    = |w_match;
    assign w_ev.len      = w_len;
    assign w_ev.address  = i_in.data.word_address;

    mwps_tally u_tally (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev       (w_ev),
        .o_in_ready (w_in_ready),
        .o_out      (o_out)
    );

endmodule

/* hw/rtl/mwps_cell.sv */
module mwps_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mwps_pkg::t_cell_ctl i_ctl,
    input  logic                i_prev,
    input  logic [31:0]         i_pattern_word,
    input  logic [31:0]         i_pattern_mask,
    input  logic [31:0]         i_code_word,
    output logic                o_bit,
    output logic                o_match
);
    import mwps_pkg::*;

    logic [31:0] r_word;
    logic [31:0] r_mask;
    logic        r_bit;
    logic        n_bit;
    logic        w_now;

    assign w_now   = i_prev && (((i_code_word ^ r_word) & r_mask) == 32'd0) && i_ctl.active;
    assign o_match = w_now && i_ctl.is_last;
    assign o_bit   = r_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.scan) begin
            n_bit = i_ctl.scan_end ? 1'b0 : w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_word <= i_pattern_word;
            r_mask <= i_pattern_mask;
        end
    end

endmodule

/* hw/rtl/mwps_tally.sv */
module mwps_tally (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mwps_pkg::t_scan_ev i_ev,
    output logic               o_in_ready,
    mwps_out_if.source         o_out
);
    import mwps_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CountLimit = '1;

    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic [31:0]            r_first;
    logic [31:0]            n_first;
    logic [WIDE_W-1:0]      w_cnt_wide;
    t_out_word              w_res;
    logic                   w_push;
    logic                   w_pop;

    t_out_word              r_out;
    logic                   r_ov;
    t_out_word              r_skid;
    logic                   r_sv;

    always_comb begin
        n_cnt   = r_cnt;
        n_first = r_first;
        if (i_ev.scan && i_ev.match) begin
            if (r_cnt == '0) begin
                n_first = i_ev.address - ((32'(i_ev.len) - 32'd1) << 2);
            end
            if (r_cnt != CountLimit) begin
                n_cnt = r_cnt + COUNT_WIDTH'(1);
            end
        end
    end

    always_comb begin
        w_cnt_wide          = WIDE_W'(n_cnt);
        w_res.match_address = 32'd0;
        w_res.hit_count     = (w_cnt_wide > WIDE_W'(16'hFFFF)) ? 16'hFFFF
                                                              : w_cnt_wide[SHOW_W-1:0];
        if (n_cnt == '0) begin
            w_res.status = ST_NONE;
        end else if (n_cnt == COUNT_WIDTH'(1)) begin
            w_res.status        = ST_UNIQUE;
            w_res.match_address = n_first;
        end else begin
            w_res.status = ST_AMBIG;
        end
    end

    assign w_push      = i_ev.scan && i_ev.scan_end;
    assign w_pop       = r_ov && o_out.ready;
    assign o_in_ready  = !r_sv;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_first <= 32'd0;
        end else if (w_push) begin
            r_cnt   <= '0;
            r_first <= 32'd0;
        end else begin
            r_cnt   <= n_cnt;
            r_first <= n_first;
        end
    end

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_pop) begin
                r_sv <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_ov || w_pop) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (w_pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_ov || w_pop) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry held while output register empty");

    a_scan_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (r_cnt == '0))
        else $error("match count not cleared after scan end");

    a_first_tracks_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_first == 32'd0))
        else $error("first address set without a counted match");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> !w_push)
        else $error("result produced while both output slots full");
`endif

endmodule
